[hw/rtl/apt_pkg.sv]
// ---------------------------------------------------------------------------
// Animation phase tracker package
// Shared types, register codes and constants for the phase tracker block.
// ---------------------------------------------------------------------------
package apt_pkg;

  // Default number of table entries.
  localparam int unsigned APT_TABLE_ENTRIES = 64;

  // FNV-1a 64-bit offset basis.
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN = 2'd2;

  // Configuration reset values.
  localparam logic [31:0] CFG_TICKS_RST    = 32'd1000;
  localparam logic [15:0] CFG_RATE_NUM_RST = 16'd60;
  localparam logic [15:0] CFG_RATE_DEN_RST = 16'd1;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [31:0] ticks_per_second;
    logic [15:0] target_rate_num;
    logic [15:0] target_rate_den;
  } apt_cfg_t;

  // One input beat.
  typedef struct packed {
    logic               kind;
    logic [47:0]        instance_req;
    logic [63:0]        resource_name;
    logic signed [31:0] sequence_req;
    logic signed [31:0] native_slot;
    logic signed [47:0] clock_ticks;
    logic [31:0]        presentation_epoch;
    logic signed [7:0]  world_active;
    logic [15:0]        native_rate_num;
    logic [15:0]        native_rate_den;
    logic [15:0]        phase_count;
  } apt_in_t;

  // One result beat.
  typedef struct packed {
    logic        valid_res;
    logic [15:0] phase;
    logic        occurrence_reset;
    logic        paused;
    logic [31:0] dropped_count;
  } apt_out_t;

  // Classification made by the front end.
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INVALID,
    OP_SAMPLE
  } apt_op_t;

  // Descriptor handed from the front end to the back end.
  typedef struct packed {
    apt_op_t op;
    apt_in_t item;
  } apt_desc_t;

  // One table entry.
  typedef struct packed {
    logic               used;
    logic [47:0]        inst;
    logic [63:0]        name;
    logic [31:0]        sequence_no;
    logic [31:0]        slot;
    logic [31:0]        epoch;
    logic signed [47:0] last_ticks;
    logic signed [47:0] slot_start;
    logic signed [47:0] pause_start;
    logic               paused;
    logic [15:0]        phase;
  } apt_entry_t;

  // Front end states.
  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } apt_fstate_t;

  // Back end states.
  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_CHECK,
    B_DECIDE,
    B_MUL_LOAD,
    B_MUL_RUN,
    B_DIV,
    B_WRITE
  } apt_bstate_t;

  // Sequence of products formed by the shared multiplier.
  typedef enum logic [2:0] {
    MS_SLOT_ND,
    MS_SN_T,
    MS_T_ND,
    MS_E_NN,
    MS_NN_TD,
    MS_Q1_T,
    MS_S_TN
  } apt_mstep_t;

  // Status from the back end.
  typedef struct packed {
    logic init_busy;
  } apt_bstat_t;

endpackage

[hw/rtl/apt_front.sv]
// ---------------------------------------------------------------------------
// Phase tracker front end
// Accepts beats, checks validity and hashes the key down to a home slot.
// ---------------------------------------------------------------------------
module apt_front
  import apt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = APT_TABLE_ENTRIES,
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          hold,
  input  apt_cfg_t      cfg,
  input  apt_in_t       item,
  output logic          busy,
  output logic          push_valid,
  input  logic          push_ready,
  output apt_desc_t     push_desc,
  output logic [IW-1:0] push_home
);

  localparam logic [IW+3:0] N_EXT = (IW+4)'(TABLE_ENTRIES);

  apt_fstate_t   state_r, state_nxt;
  apt_in_t       item_r, item_nxt;
  apt_op_t       op_r, op_nxt;
  logic [63:0]   hash_r, hash_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [IW-1:0] rem_r, rem_nxt;
  logic [63:0]   mix;
  logic          bad;

  // Multiply by the FNV prime 2^40 + 0x1B3 as a sum of shifts.
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  // Fold one more hash nibble into the running remainder by four trial subtractions.
  function automatic logic [IW-1:0] mod_step(input logic [IW-1:0] r, input logic [3:0] nib);
    logic [IW+3:0] t;
    t = {r, nib};
    for (int k = 3; k >= 0; k--) begin
      if (t >= (N_EXT << k)) begin
        t = t - (N_EXT << k);
      end
    end
    return t[IW-1:0];
  endfunction

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    item_r <= item_nxt;
    op_r   <= op_nxt;
    hash_r <= hash_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
  end

  // Validity check of an incoming sample.
  always_comb begin
    bad = (item.instance_req == '0) || item.sequence_req[31] || item.native_slot[31] ||
          item.clock_ticks[47] || (cfg.ticks_per_second == '0) || item.world_active[7] ||
          (item.native_rate_num == '0) || (item.native_rate_den == '0) ||
          (cfg.target_rate_num == '0) || (cfg.target_rate_den == '0) ||
          (item.phase_count == '0);
  end

  // Next state: hash one name byte a cycle, then the instance, then reduce one nibble a cycle.
  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    op_nxt     = op_r;
    hash_nxt   = hash_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    push_valid = 1'b0;
    mix        = (cnt_r == 7'd8) ? {16'd0, item_r.instance_req}
                                 : {56'd0, item_r.resource_name[cnt_r[2:0]*8 +: 8]};
    unique case (state_r)
      F_IDLE: begin
        if (start && !hold) begin
          item_nxt = item;
          if (item.kind) begin
            op_nxt    = OP_CLEAR;
            state_nxt = F_PUSH;
          end else if (bad) begin
            op_nxt    = OP_INVALID;
            state_nxt = F_PUSH;
          end else begin
            op_nxt    = OP_SAMPLE;
            hash_nxt  = FNV_BASIS;
            cnt_nxt   = '0;
            rem_nxt   = '0;
            state_nxt = F_HASH;
          end
        end
      end
      F_HASH: begin
        hash_nxt = fnv_mul(hash_r ^ mix);
        if (cnt_r == 7'd8) begin
          cnt_nxt   = '0;
          state_nxt = F_MOD;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      // Remainder of the hash by the table size, top nibble first.
      F_MOD: begin
        hash_nxt = hash_r << 4;
        rem_nxt  = mod_step(rem_r, hash_r[63:60]);
        if (cnt_r == 7'd15) begin
          state_nxt = F_PUSH;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign busy      = (state_r != F_IDLE) || hold;
  assign push_desc = '{op: op_r, item: item_r};
  assign push_home = rem_r;

endmodule

[hw/rtl/apt_queue.sv]
// ---------------------------------------------------------------------------
// Phase tracker descriptor queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module apt_queue
  import apt_pkg::*;
#(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  logic [DATA_W-1:0] slot_q [2];
  logic              wptr_r, rptr_r;
  logic [1:0]        count_r;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_q[wptr_r] <= wdata;
    end
  end

  assign rdata = slot_q[rptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

`ifndef SYNTHESIS
  // The back end never takes from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue popped while empty");
`endif

endmodule

[hw/rtl/apt_back.sv]
// ---------------------------------------------------------------------------
// Phase tracker back end
// Probes the entry table, updates the entry and works out the phase.
// ---------------------------------------------------------------------------
module apt_back
  import apt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = APT_TABLE_ENTRIES,
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  apt_cfg_t      cfg,
  input  logic          q_empty,
  input  apt_desc_t     q_desc,
  input  logic [IW-1:0] q_home,
  output logic          q_pop,
  output logic          out_strobe,
  output apt_out_t      out_res,
  output apt_bstat_t    stat
);

  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [IW:0]   N_W      = (IW+1)'(TABLE_ENTRIES);

  apt_bstate_t state_r, state_nxt;
  apt_desc_t   desc_r, desc_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW:0]   pcnt_r, pcnt_nxt;
  logic [IW-1:0] sweep_r, sweep_nxt;
  apt_entry_t  ent_r, ent_nxt;
  logic        created_r, created_nxt;
  logic        occ_r, occ_nxt;
  logic [31:0] drop_r, drop_nxt;
  apt_out_t    out_r, out_nxt;
  logic        strobe_r, strobe_nxt;
  apt_mstep_t  step_r, step_nxt;
  logic [111:0] ma_r, ma_nxt;
  logic [111:0] acc_r, acc_nxt;
  logic [31:0]  mb_r, mb_nxt;
  logic signed [47:0] start_r, start_nxt;
  logic signed [47:0] eff_r, eff_nxt;
  logic [46:0] sn_r, sn_nxt;
  logic [78:0] p1_r, p1_nxt;
  logic [47:0] lim_r, lim_nxt;
  logic [63:0] x_r, x_nxt;
  logic [31:0] q1_r, q1_nxt;
  logic [63:0] den_r, den_nxt;
  logic [95:0] num_r, num_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [15:0] q_r, q_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;

  // Table memory with one write and one registered read port.
  apt_entry_t    mem [TABLE_ENTRIES];
  apt_entry_t    rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  apt_entry_t    wr_data;

  // Combinational helpers.
  logic               restart;
  logic               hit;
  logic [47:0]        ediff;
  logic [47:0]        e_val;
  logic [64:0]        r2;
  logic               ge;
  logic [16:0]        q2;
  logic [IW:0]        pcnt_inc;
  logic signed [47:0] clk_t;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_INIT;
      sweep_r  <= '0;
      drop_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sweep_r  <= sweep_nxt;
      drop_r   <= drop_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    desc_r    <= desc_nxt;
    idx_r     <= idx_nxt;
    pcnt_r    <= pcnt_nxt;
    ent_r     <= ent_nxt;
    created_r <= created_nxt;
    occ_r     <= occ_nxt;
    out_r     <= out_nxt;
    step_r    <= step_nxt;
    ma_r      <= ma_nxt;
    acc_r     <= acc_nxt;
    mb_r      <= mb_nxt;
    start_r   <= start_nxt;
    eff_r     <= eff_nxt;
    sn_r      <= sn_nxt;
    p1_r      <= p1_nxt;
    lim_r     <= lim_nxt;
    x_r       <= x_nxt;
    q1_r      <= q1_nxt;
    den_r     <= den_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    dcnt_r    <= dcnt_nxt;
  end

  // Datapath helpers shared by several states.
  always_comb begin
    clk_t    = desc_r.item.clock_ticks;
    hit      = (rd_data_r.inst == desc_r.item.instance_req) &&
               (rd_data_r.name == desc_r.item.resource_name);
    restart  = created_r || (ent_r.sequence_no != desc_r.item.sequence_req) ||
               (ent_r.slot != desc_r.item.native_slot) || (clk_t < ent_r.last_ticks);
    ediff    = eff_r - start_r;
    e_val    = (eff_r > start_r) ? ediff : '0;
    r2       = {rem_r, num_r[95]};
    ge       = (r2 >= {1'b0, den_r});
    q2       = {q_r, ge};
    pcnt_inc = pcnt_r + (IW+1)'(1);
  end

  // Sequencer: clear, probe, decide, multiply, divide and write back.
  always_comb begin
    state_nxt   = state_r;
    desc_nxt    = desc_r;
    idx_nxt     = idx_r;
    pcnt_nxt    = pcnt_r;
    sweep_nxt   = sweep_r;
    ent_nxt     = ent_r;
    created_nxt = created_r;
    occ_nxt     = occ_r;
    drop_nxt    = drop_r;
    out_nxt     = out_r;
    strobe_nxt  = 1'b0;
    step_nxt    = step_r;
    ma_nxt      = ma_r;
    acc_nxt     = acc_r;
    mb_nxt      = mb_r;
    start_nxt   = start_r;
    eff_nxt     = eff_r;
    sn_nxt      = sn_r;
    p1_nxt      = p1_r;
    lim_nxt     = lim_r;
    x_nxt       = x_r;
    q1_nxt      = q1_r;
    den_nxt     = den_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    dcnt_nxt    = dcnt_r;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = ent_r;

    unique case (state_r)
      // Clearing pass after reset.
      B_INIT: begin
        wr_en   = 1'b1;
        wr_addr = sweep_r;
        wr_data = '0;
        if (sweep_r == LAST_IDX) begin
          state_nxt = B_IDLE;
        end else begin
          sweep_nxt = sweep_r + IW'(1);
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          desc_nxt = q_desc;
          unique case (q_desc.op)
            OP_CLEAR: begin
              drop_nxt  = '0;
              sweep_nxt = '0;
              state_nxt = B_CLEAR;
            end
            OP_INVALID: begin
              out_nxt               = '0;
              out_nxt.dropped_count = drop_r;
              strobe_nxt            = 1'b1;
            end
            OP_SAMPLE: begin
              idx_nxt   = q_home;
              pcnt_nxt  = '0;
              state_nxt = B_CHECK;
            end
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      // Sweep for a clear beat, then report the empty result.
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_r;
        wr_data = '0;
        if (sweep_r == LAST_IDX) begin
          out_nxt    = '0;
          strobe_nxt = 1'b1;
          state_nxt  = B_IDLE;
        end else begin
          sweep_nxt = sweep_r + IW'(1);
        end
      end
      // One probe per cycle; the read for the next slot is already issued.
      B_CHECK: begin
        if (!rd_data_r.used) begin
          ent_nxt      = rd_data_r;
          ent_nxt.used = 1'b1;
          ent_nxt.inst = desc_r.item.instance_req;
          ent_nxt.name = desc_r.item.resource_name;
          created_nxt  = 1'b1;
          state_nxt    = B_DECIDE;
        end else if (hit) begin
          ent_nxt     = rd_data_r;
          created_nxt = 1'b0;
          state_nxt   = B_DECIDE;
        end else if (pcnt_inc == N_W) begin
          // Table full: count a drop.
          if (drop_r != '1) begin
            drop_nxt = drop_r + 32'd1;
          end
          out_nxt               = '0;
          out_nxt.dropped_count = (drop_r != '1) ? drop_r + 32'd1 : drop_r;
          strobe_nxt            = 1'b1;
          state_nxt             = B_IDLE;
        end else begin
          pcnt_nxt = pcnt_inc;
          idx_nxt  = (idx_r == LAST_IDX) ? '0 : idx_r + IW'(1);
        end
      end
      B_DECIDE: begin
        step_nxt = MS_SLOT_ND;
        if (restart) begin
          ent_nxt.sequence_no = desc_r.item.sequence_req;
          ent_nxt.slot        = desc_r.item.native_slot;
          ent_nxt.epoch       = desc_r.item.presentation_epoch;
          ent_nxt.last_ticks  = clk_t;
          ent_nxt.slot_start  = clk_t;
          ent_nxt.pause_start = clk_t;
          ent_nxt.paused      = (desc_r.item.world_active == '0);
          start_nxt           = clk_t;
          eff_nxt             = clk_t;
          occ_nxt             = 1'b1;
          state_nxt           = B_MUL_LOAD;
        end else if (desc_r.item.presentation_epoch != ent_r.epoch) begin
          occ_nxt            = 1'b0;
          eff_nxt            = clk_t;
          start_nxt          = ent_r.slot_start;
          ent_nxt.epoch      = desc_r.item.presentation_epoch;
          ent_nxt.last_ticks = clk_t;
          if (desc_r.item.world_active == '0) begin
            // Pause freezes time at the pause start.
            if (!ent_r.paused) begin
              ent_nxt.paused      = 1'b1;
              ent_nxt.pause_start = clk_t;
              eff_nxt             = clk_t;
            end else begin
              eff_nxt = ent_r.pause_start;
            end
          end else if (ent_r.paused) begin
            // Resume shifts the slot start by the paused span.
            ent_nxt.slot_start = ent_r.slot_start + (clk_t - ent_r.pause_start);
            ent_nxt.paused     = 1'b0;
            start_nxt          = ent_r.slot_start + (clk_t - ent_r.pause_start);
          end
          state_nxt = B_MUL_LOAD;
        end else begin
          // Same epoch: return the held phase.
          out_nxt.valid_res        = 1'b1;
          out_nxt.phase            = ent_r.phase;
          out_nxt.occurrence_reset = 1'b0;
          out_nxt.paused           = ent_r.paused;
          out_nxt.dropped_count    = drop_r;
          strobe_nxt               = 1'b1;
          state_nxt                = B_IDLE;
        end
      end
      // Operand selection for the shared shift-add multiplier.
      B_MUL_LOAD: begin
        acc_nxt = '0;
        unique case (step_r)
          MS_SLOT_ND: begin
            ma_nxt = 112'(desc_r.item.native_slot[30:0]);
            mb_nxt = 32'(desc_r.item.native_rate_den);
          end
          MS_SN_T: begin
            ma_nxt = 112'(sn_r);
            mb_nxt = cfg.ticks_per_second;
          end
          MS_T_ND: begin
            ma_nxt = 112'(cfg.ticks_per_second);
            mb_nxt = 32'(desc_r.item.native_rate_den);
          end
          MS_E_NN: begin
            ma_nxt = 112'(e_val);
            mb_nxt = 32'(desc_r.item.native_rate_num);
          end
          MS_NN_TD: begin
            ma_nxt = 112'(desc_r.item.native_rate_num);
            mb_nxt = 32'(cfg.target_rate_den);
          end
          MS_Q1_T: begin
            ma_nxt = 112'(q1_r);
            mb_nxt = cfg.ticks_per_second;
          end
          MS_S_TN: begin
            ma_nxt = 112'({1'b0, p1_r} + 80'(x_r));
            mb_nxt = 32'(cfg.target_rate_num);
          end
          default: begin
            ma_nxt = '0;
            mb_nxt = '0;
          end
        endcase
        state_nxt = B_MUL_RUN;
      end
      // One multiplier bit per cycle until the remaining bits are zero.
      B_MUL_RUN: begin
        if (mb_r == '0) begin
          step_nxt  = apt_mstep_t'(step_r + 3'd1);
          state_nxt = B_MUL_LOAD;
          unique case (step_r)
            MS_SLOT_ND: sn_nxt = acc_r[46:0];
            MS_SN_T:    p1_nxt = acc_r[78:0];
            MS_T_ND: begin
              lim_nxt = (acc_r[47:0] > 48'(desc_r.item.native_rate_num))
                      ? acc_r[47:0] - 48'(desc_r.item.native_rate_num) : '0;
            end
            MS_E_NN: begin
              // Clamp to just under one slot, kept exact.
              x_nxt = (acc_r[63:0] > 64'(lim_r)) ? 64'(lim_r) : acc_r[63:0];
            end
            MS_NN_TD:   q1_nxt  = acc_r[31:0];
            MS_Q1_T:    den_nxt = acc_r[63:0];
            MS_S_TN: begin
              num_nxt   = acc_r[95:0];
              rem_nxt   = '0;
              q_nxt     = '0;
              dcnt_nxt  = '0;
              state_nxt = B_DIV;
            end
            default: state_nxt = B_IDLE;
          endcase
        end else begin
          if (mb_r[0]) begin
            acc_nxt = acc_r + ma_r;
          end
          ma_nxt = ma_r << 1;
          mb_nxt = mb_r >> 1;
        end
      end
      // Restoring division, quotient folded modulo the phase count.
      B_DIV: begin
        rem_nxt = ge ? 64'(r2 - {1'b0, den_r}) : r2[63:0];
        num_nxt = num_r << 1;
        q_nxt   = (q2 >= {1'b0, desc_r.item.phase_count})
                ? 16'(q2 - {1'b0, desc_r.item.phase_count}) : q2[15:0];
        if (dcnt_r == 7'd95) begin
          ent_nxt.phase = q_nxt;
          state_nxt     = B_WRITE;
        end else begin
          dcnt_nxt = dcnt_r + 7'd1;
        end
      end
      B_WRITE: begin
        wr_en                    = 1'b1;
        out_nxt.valid_res        = 1'b1;
        out_nxt.phase            = ent_r.phase;
        out_nxt.occurrence_reset = occ_r;
        out_nxt.paused           = ent_r.paused;
        out_nxt.dropped_count    = drop_r;
        strobe_nxt               = 1'b1;
        state_nxt                = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign rd_addr        = idx_nxt;
  assign out_strobe     = strobe_r;
  assign out_res        = out_r;
  assign stat.init_busy = (state_r == B_INIT);

`ifndef SYNTHESIS
  // A result without a phase carries no phase, restart or pause flag.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !out_r.valid_res) |->
      (out_r.phase == '0) && !out_r.occurrence_reset && !out_r.paused)
    else $error("invalid result carries phase data");
`endif
`ifndef SYNTHESIS
  // The folded quotient stays below the phase count.
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (q_r < desc_r.item.phase_count))
    else $error("phase quotient out of range");
`endif
`ifndef SYNTHESIS
  // No result leaves during the clearing pass after reset.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_INIT) |=> !strobe_r)
    else $error("result during clearing pass");
`endif

endmodule

[hw/rtl/animation_phase_tracker_unit.sv]
// ---------------------------------------------------------------------------
// Animation phase tracker
// Tracks animation instances in a hashed table and reports timeline phases.
// ---------------------------------------------------------------------------
//  Channel  Ports                              Handshake
//  input    start, busy, in_item               beat taken when start & !busy
//  result   out_strobe, out_res                one-cycle strobe, cannot stall
//  config   cfg_we, cfg_index, cfg_data        write when cfg_we is high
//
// For a sample the front end runs nine hash steps and a 16-step nibble
// reduction to the home slot; clear and invalid beats skip both.
// The back end probes one table entry per cycle, then runs seven shift-add
// products (one bit per cycle) and a 96-step division when a phase must be
// computed. After reset, and for each clear beat, a sweep over every entry
// empties the table; busy stays high during the sweep after reset.
// Results are strobed for one cycle and the receiver cannot stall them.
// ---------------------------------------------------------------------------
module animation_phase_tracker_unit
  import apt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = APT_TABLE_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  apt_in_t              in_item,
  output logic                 out_strobe,
  output apt_out_t             out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned DATA_W = $bits(apt_desc_t) + IW;

  apt_cfg_t          cfg_r;
  apt_bstat_t        bstat;
  logic              f_push, q_full, q_pop, q_empty;
  apt_desc_t         f_desc, q_desc;
  logic [IW-1:0]     f_home, q_home;
  logic [DATA_W-1:0] q_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second <= CFG_TICKS_RST;
      cfg_r.target_rate_num  <= CFG_RATE_NUM_RST;
      cfg_r.target_rate_den  <= CFG_RATE_DEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS:    cfg_r.ticks_per_second <= cfg_data;
        CFG_RATE_NUM: cfg_r.target_rate_num  <= cfg_data[15:0];
        CFG_RATE_DEN: cfg_r.target_rate_den  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front end: accept, classify, hash.
  apt_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .hold       (bstat.init_busy),
    .cfg        (cfg_r),
    .item       (in_item),
    .busy       (busy),
    .push_valid (f_push),
    .push_ready (!q_full),
    .push_desc  (f_desc),
    .push_home  (f_home)
  );

  // Queue between the two halves.
  apt_queue #(.DATA_W(DATA_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push && !q_full),
    .wdata ({f_desc, f_home}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_desc = q_rdata[DATA_W-1:IW];
  assign q_home = q_rdata[IW-1:0];

  // Back end: table, arithmetic and results.
  apt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_desc     (q_desc),
    .q_home     (q_home),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .stat       (bstat)
  );

endmodule
